[rtl/dtsv_pkg.sv]
// ----------------------------------------------------------------------------
// dtsv_pkg
// Shared types, codes and helper functions of the date/time string validator.
// ----------------------------------------------------------------------------
package dtsv_pkg;

  localparam int unsigned FmtW       = 4;
  localparam int unsigned QueueDepth = 2;

  // format register codes
  localparam logic [FmtW-1:0] FMT_MONTH     = 4'd0;
  localparam logic [FmtW-1:0] FMT_DATE      = 4'd1;
  localparam logic [FmtW-1:0] FMT_YEARLESS  = 4'd2;
  localparam logic [FmtW-1:0] FMT_TIME      = 4'd3;
  localparam logic [FmtW-1:0] FMT_LOCAL_DT  = 4'd4;
  localparam logic [FmtW-1:0] FMT_ZONE      = 4'd5;
  localparam logic [FmtW-1:0] FMT_GLOBAL_DT = 4'd6;
  localparam logic [FmtW-1:0] FMT_WEEK      = 4'd7;
  localparam logic [FmtW-1:0] FMT_DATE_OPT  = 4'd8;
  localparam logic [FmtW-1:0] FMT_RESET     = FMT_DATE;

  typedef enum logic [3:0] {
    CC_DIGIT,
    CC_DASH,
    CC_COLON,
    CC_DOT,
    CC_PLUS,
    CC_MINUS,
    CC_ZED,
    CC_SEP,    // 'T' or space between date and time
    CC_WEE,
    CC_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        last;
  } dtsv_beat_t;

  function automatic logic year_is_leap(input logic [8:0] res);
    return (res == 9'd0) ||
           ((res[1:0] == 2'b00) && (res != 9'd100) && (res != 9'd200) && (res != 9'd300));
  endfunction

  // (res * 10 + d) mod 400 for res < 400: equals 10 * (res mod 40) + d
  function automatic logic [8:0] year_shift_in(input logic [8:0] res, input logic [3:0] d);
    logic [9:0] prod;
    logic [3:0] q40;
    logic [8:0] m40;
    prod = 10'(res[8:3]) * 10'd13;
    q40  = prod[9:6];
    m40  = res - 9'(q40 * 9'd40);
    return 9'(m40[5:0] * 9'd10) + 9'(d);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // ISO year has 53 weeks when 1 Jan is a Thursday, or a Wednesday in a leap year
  function automatic logic year_has_53_weeks(input logic [8:0] res);
    logic [8:0] prev;
    logic [1:0] q100;
    logic [8:0] sum;
    logic [4:0] f1;
    logic [3:0] f2;
    logic [2:0] dow;
    prev = (res == 9'd0) ? 9'd399 : res - 9'd1;
    if (prev >= 9'd300)      q100 = 2'd3;
    else if (prev >= 9'd200) q100 = 2'd2;
    else if (prev >= 9'd100) q100 = 2'd1;
    else                     q100 = 2'd0;
    sum = prev + 9'(prev[8:2]) - 9'(q100);
    // fold octal digits, 8 = 1 mod 7
    f1  = 5'(sum[8:6]) + 5'(sum[5:3]) + 5'(sum[2:0]);
    f2  = 4'(f1[4:3]) + 4'(f1[2:0]);
    dow = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    return (dow == 3'd3) || ((dow == 3'd2) && year_is_leap(res));
  endfunction

endpackage

[rtl/dtsv_fifo.sv]
// ----------------------------------------------------------------------------
// dtsv_fifo
// Small register queue with push/full and pop/empty sides. Depth >= 2.
// ----------------------------------------------------------------------------
module dtsv_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  logic [Width-1:0]  mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CountW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CountW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/dtsv_front.sv]
// ----------------------------------------------------------------------------
// dtsv_front
// Takes input bytes, sorts each into a character class and queues it.
// ----------------------------------------------------------------------------
module dtsv_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [7:0]          char_byte_i,
  input  logic                last_byte_i,
  output dtsv_pkg::dtsv_beat_t beat_o,
  output logic                beat_valid_o,
  input  logic                beat_pop_i
);

  import dtsv_pkg::*;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiNine  = 8'h39;
  localparam logic [7:0] AsciiDash  = 8'h2d;
  localparam logic [7:0] AsciiColon = 8'h3a;
  localparam logic [7:0] AsciiDot   = 8'h2e;
  localparam logic [7:0] AsciiPlus  = 8'h2b;
  localparam logic [7:0] AsciiZ     = 8'h5a;
  localparam logic [7:0] AsciiT     = 8'h54;
  localparam logic [7:0] AsciiSpace = 8'h20;
  localparam logic [7:0] AsciiW     = 8'h57;

  dtsv_beat_t beat_in;
  logic       empty;

  always_comb begin
    beat_in.last  = last_byte_i;
    beat_in.digit = 4'd0;
    priority if ((char_byte_i >= AsciiZero) && (char_byte_i <= AsciiNine)) begin
      beat_in.cls   = CC_DIGIT;
      beat_in.digit = 4'(char_byte_i - AsciiZero);
    end else if (char_byte_i == AsciiDash) begin
      beat_in.cls = CC_DASH;
    end else if (char_byte_i == AsciiColon) begin
      beat_in.cls = CC_COLON;
    end else if (char_byte_i == AsciiDot) begin
      beat_in.cls = CC_DOT;
    end else if (char_byte_i == AsciiPlus) begin
      beat_in.cls = CC_PLUS;
    end else if (char_byte_i == AsciiZ) begin
      beat_in.cls = CC_ZED;
    end else if ((char_byte_i == AsciiT) || (char_byte_i == AsciiSpace)) begin
      beat_in.cls = CC_SEP;
    end else if (char_byte_i == AsciiW) begin
      beat_in.cls = CC_WEE;
    end else begin
      beat_in.cls = CC_OTHER;
    end
  end

  dtsv_fifo #(
    .Width($bits(dtsv_beat_t)),
    .Depth(Depth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .full_o (full_o),
    .data_i (beat_in),
    .pop_i  (beat_pop_i),
    .empty_o(empty),
    .data_o (beat_o)
  );

  assign beat_valid_o = !empty;

endmodule

[rtl/dtsv_back.sv]
// ----------------------------------------------------------------------------
// dtsv_back
// Field parser: walks the selected format one classified beat per cycle, holding a last
// beat while the result queue is full, and produces the verdict at the string's last beat.
// ----------------------------------------------------------------------------
module dtsv_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        format_select_we_i,
  input  logic [dtsv_pkg::FmtW-1:0]   format_select_i,
  input  dtsv_pkg::dtsv_beat_t         beat_i,
  input  logic                        beat_valid_i,
  output logic                        beat_pop_o,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output logic                        res_valid_o
);

  import dtsv_pkg::*;

  localparam logic [4:0] PH_START    = 5'd0;
  localparam logic [4:0] PH_YEAR     = 5'd1;
  localparam logic [4:0] PH_MON1     = 5'd2;
  localparam logic [4:0] PH_MON2     = 5'd3;
  localparam logic [4:0] PH_END      = 5'd4;
  localparam logic [4:0] PH_DASH_DAY = 5'd5;
  localparam logic [4:0] PH_DAY1     = 5'd6;
  localparam logic [4:0] PH_DAY2     = 5'd7;
  localparam logic [4:0] PH_DATE_END = 5'd8;
  localparam logic [4:0] PH_HOUR1    = 5'd9;
  localparam logic [4:0] PH_HOUR2    = 5'd10;
  localparam logic [4:0] PH_HCOLON   = 5'd11;
  localparam logic [4:0] PH_MIN1     = 5'd12;
  localparam logic [4:0] PH_MIN2     = 5'd13;
  localparam logic [4:0] PH_TIME_HM  = 5'd14;
  localparam logic [4:0] PH_SEC1     = 5'd15;
  localparam logic [4:0] PH_SEC2     = 5'd16;
  localparam logic [4:0] PH_TIME_S   = 5'd17;
  localparam logic [4:0] PH_FRAC     = 5'd18;
  localparam logic [4:0] PH_TZ       = 5'd19;
  localparam logic [4:0] PH_TZH1     = 5'd20;
  localparam logic [4:0] PH_TZH2     = 5'd21;
  localparam logic [4:0] PH_TZ_SEP   = 5'd22;
  localparam logic [4:0] PH_TZM1     = 5'd23;
  localparam logic [4:0] PH_TZM2     = 5'd24;
  localparam logic [4:0] PH_WEEK_W   = 5'd25;
  localparam logic [4:0] PH_WK1      = 5'd26;
  localparam logic [4:0] PH_WK2      = 5'd27;
  localparam logic [4:0] PH_YL_LEAD  = 5'd28;
  localparam logic [4:0] PH_YL_DASH  = 5'd29;

  logic [FmtW-1:0] fmt_q, fmt_d;
  logic [4:0]      phase_q, phase_d;
  logic [8:0]      year_res_q, year_res_d;
  logic [2:0]      year_cnt_q, year_cnt_d;
  logic            year_nz_q, year_nz_d;
  logic [3:0]      month_q, month_d;
  logic [3:0]      first_q, first_d;
  logic [1:0]      frac_q, frac_d;
  logic            zone_neg_q, zone_neg_d;
  logic            zone_h0_q, zone_h0_d;
  logic            fail_q, fail_d;
  logic            leap_q, leap_d;
  logic            wk53_q, wk53_d;

  // values after this beat, before end-of-string clearing
  logic [4:0] eff_phase, phase_n;
  logic [8:0] year_res_n;
  logic [2:0] year_cnt_n;
  logic       year_nz_n, zone_neg_n, zone_h0_n, leap_n, wk53_n, ok;
  logic [3:0] month_n, first_n;
  logic [1:0] frac_n;
  logic       fail_n, fire, accept;
  logic       dig, zoned, timed;
  logic [3:0] d;
  logic [6:0] v;

  assign dig   = (beat_i.cls == CC_DIGIT);
  assign d     = beat_i.digit;
  assign v     = 7'({3'd0, first_q} * 7'd10) + 7'(d);
  assign zoned = (fmt_q == FMT_GLOBAL_DT) || (fmt_q == FMT_DATE_OPT);
  assign timed = (fmt_q == FMT_TIME) || (fmt_q == FMT_LOCAL_DT);
  assign fire  = beat_valid_i && (!beat_i.last || !res_full_i);

  always_comb begin
    if (phase_q != PH_START) begin
      eff_phase = phase_q;
    end else if ((fmt_q == FMT_MONTH) || (fmt_q == FMT_DATE) || (fmt_q == FMT_LOCAL_DT) ||
                 (fmt_q == FMT_GLOBAL_DT) || (fmt_q == FMT_WEEK) ||
                 (fmt_q == FMT_DATE_OPT)) begin
      eff_phase = PH_YEAR;
    end else if (fmt_q == FMT_YEARLESS) begin
      eff_phase = PH_YL_LEAD;
    end else if (fmt_q == FMT_TIME) begin
      eff_phase = PH_HOUR1;
    end else if (fmt_q == FMT_ZONE) begin
      eff_phase = PH_TZ;
    end else begin
      eff_phase = PH_START;  // unknown format: fails in the default arm
    end
  end

  always_comb begin
    phase_n    = phase_q;
    year_res_n = year_res_q;
    year_cnt_n = year_cnt_q;
    year_nz_n  = year_nz_q;
    month_n    = month_q;
    first_n    = first_q;
    frac_n     = frac_q;
    zone_neg_n = zone_neg_q;
    zone_h0_n  = zone_h0_q;
    leap_n     = leap_q;
    wk53_n     = wk53_q;
    ok         = 1'b1;
    if (!fail_q) begin
      phase_n = eff_phase;
      ok      = 1'b0;
      unique case (eff_phase)
        PH_YEAR: begin
          if (dig) begin
            year_res_n = year_shift_in(year_res_q, d);
            if (year_cnt_q != 3'd4) year_cnt_n = year_cnt_q + 3'd1;
            if (d != 4'd0) year_nz_n = 1'b1;
            ok = 1'b1;
          end else if ((beat_i.cls == CC_DASH) && (year_cnt_q == 3'd4) && year_nz_q) begin
            phase_n = (fmt_q == FMT_WEEK) ? PH_WEEK_W : PH_MON1;
            leap_n  = year_is_leap(year_res_q);
            wk53_n  = year_has_53_weeks(year_res_q);
            ok      = 1'b1;
          end
        end
        PH_YL_LEAD: begin
          if (beat_i.cls == CC_DASH) begin
            phase_n = PH_YL_DASH;
            ok      = 1'b1;
          end else if (dig) begin
            first_n = d;
            phase_n = PH_MON2;
            ok      = 1'b1;
          end
        end
        PH_YL_DASH: begin
          if (beat_i.cls == CC_DASH) begin
            phase_n = PH_MON1;
            ok      = 1'b1;
          end
        end
        PH_MON1, PH_DAY1, PH_HOUR1, PH_MIN1, PH_SEC1, PH_TZH1, PH_TZM1, PH_WK1: begin
          if (dig) begin
            first_n = d;
            phase_n = eff_phase + 5'd1;
            ok      = 1'b1;
          end
        end
        PH_MON2: begin
          if (dig && (v != 7'd0) && (v <= 7'd12)) begin
            month_n = v[3:0];
            phase_n = (fmt_q == FMT_MONTH) ? PH_END : PH_DASH_DAY;
            ok      = 1'b1;
          end
        end
        PH_DASH_DAY: begin
          if (beat_i.cls == CC_DASH) begin
            phase_n = PH_DAY1;
            ok      = 1'b1;
          end
        end
        PH_DAY2: begin
          if (dig && (v != 7'd0) &&
              (v <= 7'(month_days(month_q, (fmt_q == FMT_YEARLESS) || leap_q)))) begin
            phase_n = PH_DATE_END;
            ok      = 1'b1;
          end
        end
        PH_DATE_END: begin
          if (((fmt_q == FMT_LOCAL_DT) || zoned) && (beat_i.cls == CC_SEP)) begin
            phase_n = PH_HOUR1;
            ok      = 1'b1;
          end
        end
        PH_HOUR2: begin
          if (dig && (v <= 7'd23)) begin
            phase_n = PH_HCOLON;
            ok      = 1'b1;
          end
        end
        PH_HCOLON: begin
          if (beat_i.cls == CC_COLON) begin
            phase_n = PH_MIN1;
            ok      = 1'b1;
          end
        end
        PH_MIN2, PH_SEC2: begin
          if (dig && (v <= 7'd59)) begin
            phase_n = (eff_phase == PH_MIN2) ? PH_TIME_HM : PH_TIME_S;
            ok      = 1'b1;
          end
        end
        PH_TIME_HM, PH_TIME_S, PH_FRAC, PH_TZ: begin
          if ((eff_phase == PH_TIME_HM) && (beat_i.cls == CC_COLON)) begin
            phase_n = PH_SEC1;
            ok      = 1'b1;
          end else if ((eff_phase == PH_TIME_S) && (beat_i.cls == CC_DOT)) begin
            frac_n  = 2'd0;
            phase_n = PH_FRAC;
            ok      = 1'b1;
          end else if ((eff_phase == PH_FRAC) && dig) begin
            if (frac_q != 2'd3) begin
              frac_n = frac_q + 2'd1;
              ok     = 1'b1;
            end
          end else if ((eff_phase == PH_TZ) ||
                       (zoned && ((eff_phase != PH_FRAC) || (frac_q != 2'd0)))) begin
            // zone start: Z or a sign; the minus sign comes in classed as a dash
            if (beat_i.cls == CC_ZED) begin
              phase_n = PH_END;
              ok      = 1'b1;
            end else if ((beat_i.cls == CC_PLUS) || (beat_i.cls == CC_DASH)) begin
              zone_neg_n = (beat_i.cls == CC_DASH);
              phase_n    = PH_TZH1;
              ok         = 1'b1;
            end
          end
        end
        PH_TZH2: begin
          if (dig && (v <= 7'd23)) begin
            zone_h0_n = (v == 7'd0);
            phase_n   = PH_TZ_SEP;
            ok        = 1'b1;
          end
        end
        PH_TZ_SEP: begin
          if (beat_i.cls == CC_COLON) begin
            phase_n = PH_TZM1;
            ok      = 1'b1;
          end else if (dig) begin
            first_n = d;
            phase_n = PH_TZM2;
            ok      = 1'b1;
          end
        end
        PH_TZM2: begin
          // -00:00 is not a valid offset
          if (dig && (v <= 7'd59) && !(zone_neg_q && zone_h0_q && (v == 7'd0))) begin
            phase_n = PH_END;
            ok      = 1'b1;
          end
        end
        PH_WEEK_W: begin
          if (beat_i.cls == CC_WEE) begin
            phase_n = PH_WK1;
            ok      = 1'b1;
          end
        end
        PH_WK2: begin
          if (dig && (v != 7'd0) && (v <= (wk53_q ? 7'd53 : 7'd52))) begin
            phase_n = PH_END;
            ok      = 1'b1;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  assign fail_n = fail_q || !ok;

  always_comb begin
    accept = 1'b0;
    if (!fail_n && (fmt_q <= FMT_DATE_OPT)) begin
      unique case (phase_n)
        PH_END:                accept = 1'b1;
        PH_DATE_END:           accept = (fmt_q == FMT_DATE) || (fmt_q == FMT_YEARLESS) ||
                                        (fmt_q == FMT_DATE_OPT);
        PH_TIME_HM, PH_TIME_S: accept = timed;
        PH_FRAC:               accept = timed && (frac_n != 2'd0);
        default:               accept = 1'b0;
      endcase
    end
  end

  assign beat_pop_o  = fire;
  assign res_push_o  = fire && beat_i.last;
  assign res_valid_o = accept;

  always_comb begin
    fmt_d      = format_select_we_i ? format_select_i : fmt_q;
    phase_d    = phase_q;
    year_res_d = year_res_q;
    year_cnt_d = year_cnt_q;
    year_nz_d  = year_nz_q;
    month_d    = month_q;
    first_d    = first_q;
    frac_d     = frac_q;
    zone_neg_d = zone_neg_q;
    zone_h0_d  = zone_h0_q;
    fail_d     = fail_q;
    leap_d     = leap_q;
    wk53_d     = wk53_q;
    if (fire && beat_i.last) begin
      phase_d    = PH_START;
      year_res_d = '0;
      year_cnt_d = '0;
      year_nz_d  = 1'b0;
      month_d    = '0;
      first_d    = '0;
      frac_d     = '0;
      zone_neg_d = 1'b0;
      zone_h0_d  = 1'b0;
      fail_d     = 1'b0;
      // year residue zero: leap, 52 weeks
      leap_d     = 1'b1;
      wk53_d     = 1'b0;
    end else if (fire) begin
      phase_d    = phase_n;
      year_res_d = year_res_n;
      year_cnt_d = year_cnt_n;
      year_nz_d  = year_nz_n;
      month_d    = month_n;
      first_d    = first_n;
      frac_d     = frac_n;
      zone_neg_d = zone_neg_n;
      zone_h0_d  = zone_h0_n;
      fail_d     = fail_n;
      leap_d     = leap_n;
      wk53_d     = wk53_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= FMT_RESET;
      phase_q    <= PH_START;
      year_res_q <= '0;
      year_cnt_q <= '0;
      year_nz_q  <= 1'b0;
      month_q    <= '0;
      first_q    <= '0;
      frac_q     <= '0;
      zone_neg_q <= 1'b0;
      zone_h0_q  <= 1'b0;
      fail_q     <= 1'b0;
      leap_q     <= 1'b1;
      wk53_q     <= 1'b0;
    end else begin
      fmt_q      <= fmt_d;
      phase_q    <= phase_d;
      year_res_q <= year_res_d;
      year_cnt_q <= year_cnt_d;
      year_nz_q  <= year_nz_d;
      month_q    <= month_d;
      first_q    <= first_d;
      frac_q     <= frac_d;
      zone_neg_q <= zone_neg_d;
      zone_h0_q  <= zone_h0_d;
      fail_q     <= fail_d;
      leap_q     <= leap_d;
      wk53_q     <= wk53_d;
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && beat_i.last |=> (phase_q == PH_START) && !fail_q && (year_cnt_q == 3'd0))
    else $error("parser not cleared after last beat");

  a_year_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    year_cnt_q <= 3'd4)
    else $error("year digit count past saturation");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DASH_DAY) || (phase_q == PH_DAY1) || (phase_q == PH_DAY2)
    |-> (month_q >= 4'd1) && (month_q <= 4'd12))
    else $error("day phase with month out of range");

  a_fail_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q && !(fire && beat_i.last) |=> $stable(phase_q) && fail_q)
    else $error("phase moved after failure");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("verdict pushed into full result queue");
`endif

endmodule

[rtl/date_time_string_validator_top.sv]
// ----------------------------------------------------------------------------
// date_time_string_validator_top
// Checks a byte stream against one of nine date/time string formats.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive char_byte_i/last_byte_i with push; a beat is taken
//   when push is high and full is low. last_byte_i marks a string's end.
//   Result queue side: while empty is low, string_valid_o holds the verdict of
//   the oldest finished string; pop takes it. One verdict per string, none
//   for other bytes.
//   format_select_we_i/format_select_i load the format code (reset: date).
//   Codes 9 to 15 reject every string.
// Timing:
//   One byte per cycle sustained while the result queue has room. A verdict
//   reaches the result ports through the input queue and the result queue: the
//   last byte is registered in the input queue, then the parser's field update,
//   which sets the rate, writes the verdict into the result queue.
//   When pop is held low, verdicts collect in the result queue; once it is
//   full the parser holds the next last byte, the input queue fills and full
//   rises. Non-final bytes ahead of it keep flowing meanwhile.
// Reset clears both queues and the parser and selects the date format.
// ----------------------------------------------------------------------------
module date_time_string_validator_top #(
  parameter int unsigned QueueDepth = dtsv_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                char_byte_i,
  input  logic                      last_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      string_valid_o,
  input  logic                      format_select_we_i,
  input  logic [dtsv_pkg::FmtW-1:0] format_select_i
);

  import dtsv_pkg::*;

  dtsv_beat_t beat;
  logic       beat_valid, beat_pop;
  logic       res_full, res_push, res_valid;

  dtsv_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .char_byte_i (char_byte_i),
    .last_byte_i (last_byte_i),
    .beat_o      (beat),
    .beat_valid_o(beat_valid),
    .beat_pop_i  (beat_pop)
  );

  dtsv_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .format_select_we_i(format_select_we_i),
    .format_select_i   (format_select_i),
    .beat_i            (beat),
    .beat_valid_i      (beat_valid),
    .beat_pop_o        (beat_pop),
    .res_full_i        (res_full),
    .res_push_o        (res_push),
    .res_valid_o       (res_valid)
  );

  dtsv_fifo #(
    .Width(1),
    .Depth(QueueDepth)
  ) u_result_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .full_o (res_full),
    .data_i (res_valid),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (string_valid_o)
  );

endmodule

[sim/tb_date_time_string_validator_top.sv]
// ----------------------------------------------------------------------------
// tb_date_time_string_validator_top
// Byte-stream test of the date/time string validator against a local parser.
// Strings of all nine formats, and some unknown codes, are built from random
// field values. Some are broken on purpose and some are plain noise. They are
// pushed a byte at a time in bursts. A parser kept in step with the format
// register predicts the verdict at each string's last byte. The result side
// stalls in changing patterns and once holds off long enough to back the
// input up.
// ----------------------------------------------------------------------------
module tb_date_time_string_validator_top;
  import dtsv_pkg::*;

  localparam logic [FmtW-1:0] FMT_UNKNOWN_LO = 4'd9;
  localparam logic [FmtW-1:0] FMT_UNKNOWN_HI = 4'd15;
  localparam int RANDOM_BYTES = 950;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [4:0] {
    PS_START, PS_YEAR, PS_MON1, PS_MON2, PS_END, PS_DASH_DAY, PS_DAY1, PS_DAY2,
    PS_DATE_END, PS_HOUR1, PS_HOUR2, PS_HCOLON, PS_MIN1, PS_MIN2, PS_TIME_HM,
    PS_SEC1, PS_SEC2, PS_TIME_S, PS_FRAC, PS_TZ, PS_TZH1, PS_TZH2, PS_TZ_SEP,
    PS_TZM1, PS_TZM2, PS_WEEK_W, PS_WK1, PS_WK2, PS_YL_LEAD, PS_YL_DASH
  } parse_phase_e;

  typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_PATTERN} pop_mode_e;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            push      = 1'b0;
  logic            full;
  logic [7:0]      char_byte = 8'h00;
  logic            last_byte = 1'b0;
  logic            empty;
  logic            pop       = 1'b0;
  logic            string_valid;
  logic            fmt_we    = 1'b0;
  logic [FmtW-1:0] fmt_wdata = FMT_RESET;

  date_time_string_validator_top i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .char_byte_i        (char_byte),
    .last_byte_i        (last_byte),
    .empty              (empty),
    .pop                (pop),
    .string_valid_o     (string_valid),
    .format_select_we_i (fmt_we),
    .format_select_i    (fmt_wdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // parser state, kept in step with the accepted bytes
  logic [FmtW-1:0] fmt_m    = FMT_RESET;
  parse_phase_e    ph_m     = PS_START;
  logic [8:0]      yr_res_m = '0;
  logic [2:0]      yr_cnt_m = '0;
  logic            yr_nz_m  = 1'b0;
  logic [3:0]      mon_m    = '0;
  logic [3:0]      tens_m   = '0;
  logic [1:0]      frac_m   = '0;
  logic            zneg_m   = 1'b0;
  logic            zh0_m    = 1'b0;
  logic            fail_m   = 1'b0;

  bit   verdict_q[$];
  byte unsigned text_q[$];
  int   mismatch_cnt = 0;
  int   byte_cnt     = 0;
  int   burst_left   = 0;
  bit   no_gaps      = 1'b0;
  int   hold_reqs    = 0;
  int   cycle_cnt    = 0;

  function automatic void restart_parse();
    ph_m     = PS_START;
    yr_res_m = '0;
    yr_cnt_m = '0;
    yr_nz_m  = 1'b0;
    mon_m    = '0;
    tens_m   = '0;
    frac_m   = '0;
    zneg_m   = 1'b0;
    zh0_m    = 1'b0;
    fail_m   = 1'b0;
  endfunction

  function automatic bit res_is_leap(input int r);
    return (r == 0) || ((r % 4 == 0) && (r % 100 != 0));
  endfunction

  function automatic int days_in(input int m, input bit lp);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return lp ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // 53 weeks when 1 Jan falls on a Thursday, or a Wednesday in a leap year
  function automatic int weeks_in(input int r);
    int p, dow;
    p   = (r + 399) % 400;
    dow = (p + p / 4 - p / 100 + p / 400) % 7 + 1;
    return (dow == 4 || (dow == 3 && res_is_leap(r))) ? 53 : 52;
  endfunction

  function automatic bit zone_open(input logic [7:0] c);
    if (c == "Z") begin
      ph_m = PS_END;
      return 1'b1;
    end
    if (c == "+" || c == "-") begin
      zneg_m = (c == "-");
      ph_m   = PS_TZH1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] c);
    bit dig, zoned;
    int d, v;
    dig   = (c >= "0") && (c <= "9");
    d     = dig ? int'(c - "0") : 0;
    v     = int'(tens_m) * 10 + d;
    zoned = (fmt_m == FMT_GLOBAL_DT) || (fmt_m == FMT_DATE_OPT);
    if (ph_m == PS_START) begin
      case (fmt_m)
        FMT_MONTH, FMT_DATE, FMT_LOCAL_DT, FMT_GLOBAL_DT, FMT_WEEK, FMT_DATE_OPT:
          ph_m = PS_YEAR;
        FMT_YEARLESS: ph_m = PS_YL_LEAD;
        FMT_TIME:     ph_m = PS_HOUR1;
        FMT_ZONE:     ph_m = PS_TZ;
        default:      return 1'b0;
      endcase
    end
    case (ph_m)
      PS_YEAR: begin
        if (dig) begin
          yr_res_m = 9'((int'(yr_res_m) * 10 + d) % 400);
          if (yr_cnt_m < 3'd4) yr_cnt_m++;
          if (d != 0) yr_nz_m = 1'b1;
          return 1'b1;
        end
        if (c != "-" || yr_cnt_m < 3'd4 || !yr_nz_m) return 1'b0;
        ph_m = (fmt_m == FMT_WEEK) ? PS_WEEK_W : PS_MON1;
        return 1'b1;
      end
      PS_YL_LEAD: begin
        if (c == "-") begin
          ph_m = PS_YL_DASH;
          return 1'b1;
        end
        if (!dig) return 1'b0;
        tens_m = 4'(d);
        ph_m   = PS_MON2;
        return 1'b1;
      end
      PS_YL_DASH: begin
        if (c != "-") return 1'b0;
        ph_m = PS_MON1;
        return 1'b1;
      end
      // first digit of a pair; the second-digit phase follows in the encoding
      PS_MON1, PS_DAY1, PS_HOUR1, PS_MIN1, PS_SEC1, PS_TZH1, PS_TZM1, PS_WK1: begin
        if (!dig) return 1'b0;
        tens_m = 4'(d);
        ph_m   = parse_phase_e'(ph_m + 5'd1);
        return 1'b1;
      end
      PS_MON2: begin
        if (!dig || v == 0 || v > 12) return 1'b0;
        mon_m = 4'(v);
        ph_m  = (fmt_m == FMT_MONTH) ? PS_END : PS_DASH_DAY;
        return 1'b1;
      end
      PS_DASH_DAY: begin
        if (c != "-") return 1'b0;
        ph_m = PS_DAY1;
        return 1'b1;
      end
      PS_DAY2: begin
        if (!dig || v == 0 ||
            v > days_in(int'(mon_m), fmt_m == FMT_YEARLESS || res_is_leap(int'(yr_res_m))))
          return 1'b0;
        ph_m = PS_DATE_END;
        return 1'b1;
      end
      PS_DATE_END: begin
        if (!(fmt_m == FMT_LOCAL_DT || zoned) || (c != "T" && c != " ")) return 1'b0;
        ph_m = PS_HOUR1;
        return 1'b1;
      end
      PS_HOUR2: begin
        if (!dig || v > 23) return 1'b0;
        ph_m = PS_HCOLON;
        return 1'b1;
      end
      PS_HCOLON: begin
        if (c != ":") return 1'b0;
        ph_m = PS_MIN1;
        return 1'b1;
      end
      PS_MIN2: begin
        if (!dig || v > 59) return 1'b0;
        ph_m = PS_TIME_HM;
        return 1'b1;
      end
      PS_TIME_HM: begin
        if (c == ":") begin
          ph_m = PS_SEC1;
          return 1'b1;
        end
        return zoned && zone_open(c);
      end
      PS_SEC2: begin
        if (!dig || v > 59) return 1'b0;
        ph_m = PS_TIME_S;
        return 1'b1;
      end
      PS_TIME_S: begin
        if (c == ".") begin
          frac_m = '0;
          ph_m   = PS_FRAC;
          return 1'b1;
        end
        return zoned && zone_open(c);
      end
      PS_FRAC: begin
        if (dig) begin
          if (frac_m >= 2'd3) return 1'b0;
          frac_m++;
          return 1'b1;
        end
        return (frac_m != 0) && zoned && zone_open(c);
      end
      PS_TZ: return zone_open(c);
      PS_TZH2: begin
        if (!dig || v > 23) return 1'b0;
        zh0_m = (v == 0);
        ph_m  = PS_TZ_SEP;
        return 1'b1;
      end
      PS_TZ_SEP: begin
        if (c == ":") begin
          ph_m = PS_TZM1;
          return 1'b1;
        end
        if (!dig) return 1'b0;
        tens_m = 4'(d);
        ph_m   = PS_TZM2;
        return 1'b1;
      end
      PS_TZM2: begin
        if (!dig || v > 59) return 1'b0;
        if (zneg_m && zh0_m && v == 0) return 1'b0;  // -00:00 is not a zone
        ph_m = PS_END;
        return 1'b1;
      end
      PS_WEEK_W: begin
        if (c != "W") return 1'b0;
        ph_m = PS_WK1;
        return 1'b1;
      end
      PS_WK2: begin
        if (!dig || v == 0 || v > weeks_in(int'(yr_res_m))) return 1'b0;
        ph_m = PS_END;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit string_ok();
    bit timed;
    timed = (fmt_m == FMT_TIME) || (fmt_m == FMT_LOCAL_DT);
    if (fail_m || fmt_m > FMT_DATE_OPT) return 1'b0;
    case (ph_m)
      PS_END:                return 1'b1;
      PS_DATE_END:           return fmt_m == FMT_DATE || fmt_m == FMT_YEARLESS ||
                                    fmt_m == FMT_DATE_OPT;
      PS_TIME_HM, PS_TIME_S: return timed;
      PS_FRAC:               return timed && frac_m != 0;
      default:               return 1'b0;
    endcase
  endfunction

  // ---- string building ----
  function automatic void put(input logic [7:0] c);
    text_q.push_back(c);
  endfunction

  function automatic void put_2dig(input int n);
    put(8'("0" + n / 10));
    put(8'("0" + n % 10));
  endfunction

  function automatic void put_year();
    int kind, y;
    kind = $urandom_range(0, 15);
    if (kind == 0) repeat ($urandom_range(1, 3)) put(8'("0" + $urandom_range(0, 9)));
    else if (kind == 1) repeat (4) put("0");
    else if (kind <= 3) repeat ($urandom_range(5, 8)) put(8'("0" + $urandom_range(0, 9)));
    else begin
      y = $urandom_range(1, 9999);
      for (int p = 1000; p > 0; p = p / 10) put(8'("0" + (y / p) % 10));
    end
  endfunction

  function automatic void put_month_day(input bit with_day);
    int m, d;
    m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 19) : $urandom_range(1, 12);
    if ($urandom_range(0, 7) == 0) m = 2;
    put_2dig(m);
    if (!with_day) return;
    if (m == 2 && $urandom_range(0, 1)) d = $urandom_range(28, 29);
    else if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 39);
    else d = $urandom_range(1, days_in(m, 1'b1));
    put("-");
    put_2dig(d);
  endfunction

  function automatic void put_date();
    put_year();
    put("-");
    put_month_day(1'b1);
  endfunction

  function automatic void put_time();
    put_2dig(($urandom_range(0, 9) == 0) ? $urandom_range(20, 29) : $urandom_range(0, 23));
    put(":");
    put_2dig(($urandom_range(0, 9) == 0) ? $urandom_range(55, 69) : $urandom_range(0, 59));
    if ($urandom_range(0, 1)) begin
      put(":");
      put_2dig(($urandom_range(0, 9) == 0) ? $urandom_range(55, 69) : $urandom_range(0, 59));
      if ($urandom_range(0, 1)) begin
        put(".");
        repeat (($urandom_range(0, 7) < 6) ? $urandom_range(1, 3) : 4 * $urandom_range(0, 1))
          put(8'("0" + $urandom_range(0, 9)));
      end
    end
  endfunction

  function automatic void put_zone();
    int h;
    if ($urandom_range(0, 3) == 0) begin
      put("Z");
      return;
    end
    put($urandom_range(0, 1) ? "+" : "-");
    if ($urandom_range(0, 3) == 0) h = 0;
    else if ($urandom_range(0, 9) == 0) h = $urandom_range(24, 29);
    else h = $urandom_range(0, 23);
    put_2dig(h);
    if ($urandom_range(0, 3) != 0) put(":");
    if (h == 0 && $urandom_range(0, 1)) put_2dig(0);
    else put_2dig(($urandom_range(0, 9) == 0) ? $urandom_range(60, 69) : $urandom_range(0, 59));
  endfunction

  function automatic void put_global();
    put_date();
    put($urandom_range(0, 1) ? "T" : " ");
    put_time();
    put_zone();
  endfunction

  function automatic void put_shape(input logic [FmtW-1:0] f);
    case (f)
      FMT_MONTH: begin
        put_year();
        put("-");
        put_month_day(1'b0);
      end
      FMT_DATE: put_date();
      FMT_YEARLESS: begin
        if ($urandom_range(0, 1)) begin
          put("-");
          put("-");
        end
        put_month_day(1'b1);
      end
      FMT_TIME: put_time();
      FMT_LOCAL_DT: begin
        put_date();
        put($urandom_range(0, 1) ? "T" : " ");
        put_time();
      end
      FMT_ZONE:      put_zone();
      FMT_GLOBAL_DT: put_global();
      FMT_WEEK: begin
        put_year();
        put("-");
        put("W");
        if ($urandom_range(0, 3) == 0) put_2dig($urandom_range(52, 53));
        else if ($urandom_range(0, 15) == 0) put_2dig($urandom_range(0, 99));
        else put_2dig($urandom_range(1, 53));
      end
      default: begin
        if ($urandom_range(0, 1)) put_date();
        else put_global();
      end
    endcase
  endfunction

  // mostly well-formed text of the selected format; the rest is foreign or damaged
  function automatic void build_string(input logic [FmtW-1:0] f);
    int k, pos;
    text_q.delete();
    k = $urandom_range(0, 19);
    if (k == 0) repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
    else put_shape((k == 1 || f > FMT_DATE_OPT) ? FmtW'($urandom_range(0, 8)) : f);
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 3))
        0: text_q[pos] = 8'($urandom_range(0, 255));
        1: if (text_q.size() > 1) text_q.delete(pos);
        2: text_q.push_back(8'($urandom_range(0, 255)));
        default: while (text_q.size() > pos + 1) void'(text_q.pop_back());
      endcase
    end
  endfunction

  function automatic void set_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  // ---- input side ----
  task automatic send_byte(input logic [7:0] c, input bit l);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 24);
      end
      burst_left--;
    end
    push      <= 1'b1;
    char_byte <= c;
    last_byte <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (!fail_m && !parse_byte(c)) fail_m = 1'b1;
    if (l) begin
      verdict_q.push_back(string_ok());
      restart_parse();
    end
    byte_cnt++;
  endtask

  task automatic send_text(input bit close);
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], close && (i == text_q.size() - 1));
  endtask

  // bytes without a verdict may still be in flight, hence the settle time
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_format(input logic [FmtW-1:0] f);
    wait_idle();
    fmt_we    <= 1'b1;
    fmt_wdata <= f;
    @(posedge clk_i);
    fmt_we    <= 1'b0;
    fmt_m      = f;
  endtask

  // ---- result side ----
  pop_mode_e  pop_mode  = POP_ALWAYS;
  int         mode_left = 0;
  int         hold_left = 0;
  int         hold_ack  = 0;
  logic [7:0] pop_mask  = 8'hff;
  bit         expected_ok;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: string_valid expected none, actual %0b", $time, string_valid);
        mismatch_cnt++;
      end else begin
        expected_ok = verdict_q.pop_front();
        if (string_valid !== expected_ok) begin
          $display("%0t: string_valid expected %0b, actual %0b",
                   $time, expected_ok, string_valid);
          mismatch_cnt++;
        end
      end
    end
    if (hold_ack != hold_reqs) begin
      hold_ack  = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode  = pop_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
        pop_mask  = 8'($urandom_range(1, 255));
      end
      mode_left--;
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
        default: begin
          pop     <= pop_mask[0];
          pop_mask = {pop_mask[0], pop_mask[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---- tests ----
  // no write yet: the format must be date; 2000 is a leap year
  task automatic test_reset_format();
    set_text("2000-02-29");
    send_text(1'b1);
    text_q.delete();
    put(8'hff);
    send_text(1'b1);
  endtask

  task automatic test_zone_cases();
    write_format(FMT_ZONE);
    set_text("Z");
    send_text(1'b1);
    set_text("-00:00");
    send_text(1'b1);
    set_text("ZZ");   // trailing byte after a complete zone
    send_text(1'b1);
    set_text("QZ");   // early failure, rest ignored
    send_text(1'b1);
    write_format(FMT_UNKNOWN_HI);
    set_text("Z");
    send_text(1'b1);
  endtask

  // zone prefix, then the format changes while the string is open
  task automatic test_format_switch();
    write_format(FMT_ZONE);
    set_text("+");
    send_text(1'b0);
    write_format(FMT_TIME);
    set_text("12:30");
    send_text(1'b1);
  endtask

  task automatic test_result_backpressure();
    write_format(FMT_ZONE);
    no_gaps = 1'b1;
    hold_reqs++;
    repeat (40) begin
      build_string(FMT_ZONE);
      send_text(1'b1);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_strings();
    logic [FmtW-1:0] f;
    int round_no, start;
    round_no = 0;
    start    = byte_cnt;
    while (byte_cnt < start + RANDOM_BYTES) begin
      if (round_no <= FMT_DATE_OPT) f = FmtW'(round_no);
      else if (round_no == FMT_DATE_OPT + 1) f = FMT_UNKNOWN_HI;
      else if ($urandom_range(0, 9) == 0) f = FmtW'($urandom_range(FMT_UNKNOWN_LO, FMT_UNKNOWN_HI));
      else f = FmtW'($urandom_range(FMT_MONTH, FMT_DATE_OPT));
      write_format(f);
      repeat ($urandom_range(6, 14)) begin
        build_string(f);
        send_text(1'b1);
      end
      round_no++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_format();
    test_zone_cases();
    test_format_switch();
    test_result_backpressure();
    test_random_strings();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
